@@ hw/rtl/csu_pkg.sv @@
// shared types and constants of the cosine similarity unit
package csu_pkg;

    localparam int ELEM_WIDTH  = 16;
    localparam int MAX_LEN     = 1024;
    localparam int PROD_WIDTH  = 2 * ELEM_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + $clog2(MAX_LEN);
    localparam int HALF_W      = ACC_WIDTH / 2;
    localparam int MUL_W       = 2 * ACC_WIDTH;
    localparam int FRAC_BITS   = 14;
    localparam int Q_BITS      = FRAC_BITS + 1;
    localparam int SRCH_W      = MUL_W + 2 * Q_BITS + 2;
    localparam int SIM_W       = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [Q_BITS-1:0] ONE_Q14 = Q_BITS'(1) << FRAC_BITS;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [ACC_WIDTH-1:0]  acc_t;

    // finished sums of one vector pair
    typedef struct packed {
        acc_t dot;
        acc_t norm_a;
        acc_t norm_b;
    } vec_t;

endpackage

@@ hw/rtl/csu_front.sv @@
// front end: element products and saturating accumulation
module csu_front
    import csu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  elem_t elem_a,
    input  elem_t elem_b,
    input  logic  is_last,
    output logic  push,
    output vec_t  push_data,
    input  logic  full
);

    function automatic acc_t sat_add(acc_t acc, prod_t p);
        logic [ACC_WIDTH:0] s;
        s = {acc[ACC_WIDTH-1], acc} + {{(ACC_WIDTH+1-PROD_WIDTH){p[PROD_WIDTH-1]}}, p};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
        begin
            return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        return acc_t'(s[ACC_WIDTH-1:0]);
    endfunction

    logic  p_vld_reg;
    logic  p_last_reg;
    prod_t p_ab_reg;
    prod_t p_aa_reg;
    prod_t p_bb_reg;
    acc_t  dot_reg;
    acc_t  na_reg;
    acc_t  nb_reg;
    acc_t  dot_next;
    acc_t  na_next;
    acc_t  nb_next;
    logic  advance;

    // only a finished vector waiting on a full queue holds the pipe
    assign advance  = !(p_vld_reg && p_last_reg && full);
    assign in_stall = !advance;

    assign dot_next = sat_add(dot_reg, p_ab_reg);
    assign na_next  = sat_add(na_reg, p_aa_reg);
    assign nb_next  = sat_add(nb_reg, p_bb_reg);

    assign push             = p_vld_reg && p_last_reg && !full;
    assign push_data.dot    = dot_next;
    assign push_data.norm_a = na_next;
    assign push_data.norm_b = nb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            dot_reg   <= '0;
            na_reg    <= '0;
            nb_reg    <= '0;
        end
        else if (advance)
        begin
            p_vld_reg <= in_valid;
            if (p_vld_reg)
            begin
                if (p_last_reg)
                begin
                    dot_reg <= '0;
                    na_reg  <= '0;
                    nb_reg  <= '0;
                end
                else
                begin
                    dot_reg <= dot_next;
                    na_reg  <= na_next;
                    nb_reg  <= nb_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            p_last_reg <= is_last;
            p_ab_reg   <= prod_t'(elem_a) * prod_t'(elem_b);
            p_aa_reg   <= prod_t'(elem_a) * prod_t'(elem_a);
            p_bb_reg   <= prod_t'(elem_b) * prod_t'(elem_b);
        end
    end

endmodule

@@ hw/rtl/csu_queue.sv @@
// short fifo of finished vector sums between front and back
module csu_queue
    import csu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  vec_t push_data,
    output logic full,
    input  logic pop,
    output vec_t pop_data,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    vec_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/csu_back.sv @@
// back end: norm product, bitwise quotient search and result register
module csu_back
    import csu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    empty,
    input  vec_t                    pop_data,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SIM_W-1:0] similarity,
    output logic                    zero_norm
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_SRCH_A = 3'd2;
    localparam logic [2:0] ST_SRCH_B = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam int K_W  = $clog2(Q_BITS);
    localparam int PP_W = 2 * HALF_W;

    logic [2:0]               state_reg;
    logic [2:0]               cnt_reg;
    logic [K_W-1:0]           k_reg;
    logic                     out_vld_reg;

    logic [ACC_WIDTH-1:0]     mag_reg;
    logic [ACC_WIDTH-1:0]     na_reg;
    logic [ACC_WIDTH-1:0]     nb_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    logic [MUL_W-1:0]         mul_acc_reg;
    logic [MUL_W-1:0]         p_reg;
    logic [SRCH_W-1:0]        r_reg;
    logic [SRCH_W-1:0]        x_reg;
    logic signed [SRCH_W-1:0] ys_reg;
    logic [SRCH_W-1:0]        ps_reg;
    logic [SRCH_W-1:0]        cand_reg;
    logic [Q_BITS-1:0]        q_reg;
    logic signed [SIM_W-1:0]  sim_reg;
    logic                     zn_reg;

    logic [ACC_WIDTH-1:0]     op_x;
    logic [ACC_WIDTH-1:0]     op_y;
    logic [HALF_W-1:0]        part_x;
    logic [HALF_W-1:0]        part_y;
    logic [PP_W-1:0]          pp;
    logic [MUL_W-1:0]         pp_shift;
    logic [MUL_W-1:0]         mul_acc_next;
    logic                     fits;
    logic signed [SRCH_W-1:0] ys_upd;
    logic [Q_BITS-1:0]        q_clamp;
    logic signed [SIM_W-1:0]  sim_value;
    logic                     out_free;
    logic                     finish;

    // one 21x21 partial product per cycle: steps 0..3 build na*nb, 4..7 build |dot|^2
    assign op_x   = cnt_reg[2] ? mag_reg : na_reg;
    assign op_y   = cnt_reg[2] ? mag_reg : nb_reg;
    assign part_x = cnt_reg[0] ? op_x[ACC_WIDTH-1:HALF_W] : op_x[HALF_W-1:0];
    assign part_y = cnt_reg[1] ? op_y[ACC_WIDTH-1:HALF_W] : op_y[HALF_W-1:0];
    assign pp     = PP_W'(part_x) * PP_W'(part_y);

    always_comb
    begin
        unique case ({cnt_reg[1], cnt_reg[0]})
            2'b00:   pp_shift = MUL_W'(pp);
            2'b11:   pp_shift = MUL_W'(pp) << (2 * HALF_W);
            default: pp_shift = MUL_W'(pp) << HALF_W;
        endcase
    end

    assign mul_acc_next = mul_acc_reg + pp_shift;

    assign fits   = cand_reg <= r_reg;
    assign ys_upd = fits ? ys_reg + $signed(ps_reg << 1) : ys_reg;

    assign q_clamp   = (q_reg > ONE_Q14) ? ONE_Q14 : q_reg;
    assign sim_value = zero_reg ? '0
                     : neg_reg  ? -$signed({1'b0, q_clamp})
                     : $signed({1'b0, q_clamp});

    assign out_free = !out_vld_reg || !out_stall;
    assign finish   = (state_reg == ST_DONE) && out_free;
    assign pop      = (state_reg == ST_IDLE) && !empty;

    assign out_valid  = out_vld_reg;
    assign similarity = sim_reg;
    assign zero_norm  = zn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            k_reg       <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cnt_reg <= '0;
                        if (pop_data.norm_a == '0 || pop_data.norm_b == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd7)
                    begin
                        k_reg     <= K_W'(Q_BITS - 1);
                        state_reg <= ST_SRCH_A;
                    end
                end
                ST_SRCH_A:
                begin
                    state_reg <= ST_SRCH_B;
                end
                ST_SRCH_B:
                begin
                    if (k_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= ST_SRCH_A;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mag_reg     <= pop_data.dot[ACC_WIDTH-1] ? ACC_WIDTH'(-pop_data.dot)
                                                     : ACC_WIDTH'(pop_data.dot);
            na_reg      <= ACC_WIDTH'(pop_data.norm_a);
            nb_reg      <= ACC_WIDTH'(pop_data.norm_b);
            neg_reg     <= pop_data.dot[ACC_WIDTH-1];
            zero_reg    <= (pop_data.norm_a == '0) || (pop_data.norm_b == '0);
            mul_acc_reg <= '0;
            q_reg       <= '0;
        end

        if (state_reg == ST_MUL)
        begin
            if (cnt_reg == 3'd3)
            begin
                p_reg       <= mul_acc_next;
                mul_acc_reg <= '0;
            end
            else if (cnt_reg == 3'd7)
            begin
                // scale |dot|^2 by 2^30 so it lines up with (2q-1)^2 * na * nb
                r_reg  <= SRCH_W'(mul_acc_next) << (2 * Q_BITS);
                x_reg  <= SRCH_W'(p_reg);
                ys_reg <= $signed(SRCH_W'(0) - (SRCH_W'(p_reg) << (Q_BITS + 1)));
                ps_reg <= SRCH_W'(p_reg) << (2 * Q_BITS);
            end
            else
            begin
                mul_acc_reg <= mul_acc_next;
            end
        end

        // candidate (d + 2^(k+1))^2 * P built from shifted running terms
        if (state_reg == ST_SRCH_A)
        begin
            cand_reg <= x_reg + SRCH_W'(ys_reg) + ps_reg;
        end

        if (state_reg == ST_SRCH_B)
        begin
            if (fits)
            begin
                x_reg <= cand_reg;
                q_reg <= q_reg | (Q_BITS'(1) << k_reg);
            end
            ys_reg <= ys_upd >>> 1;
            ps_reg <= ps_reg >> 2;
        end

        if (finish)
        begin
            sim_reg <= sim_value;
            zn_reg  <= zero_reg;
        end
    end

endmodule

@@ hw/rtl/cosine_similarity_unit_core.sv @@
// top level of the cosine similarity unit: front, queue and back
//
//  channel | signals                            | direction | meaning
//  --------+------------------------------------+-----------+---------------------------------
//  in      | in_valid, in_stall, elem_a, elem_b,| into block| one element pair, last-pair mark
//          | is_last                            |           |
//  out     | out_valid, out_stall, similarity,  | out block | cosine in q2.14, zero-norm flag
//          | zero_norm                          |           |
//
//  the front takes one pair per cycle while not stalled: one register of products, then a
//  saturating accumulate into the three 42-bit sums
//  each vector in the back takes a load, 8 steps on one shared 21x21 multiplier (na*nb,
//  then |dot|^2), 15 steps of the quotient search and one output write; a zero norm skips the
//  multiplier and the search; a two-entry queue of finished sums lets the front run on meanwhile
//  the last pair passes the product registers, the queue and the back before out_valid rises
//  in_stall rises only when a last pair finds the queue full
//  reset clears the sums, the queue and the output valid; no clearing pass is needed
module cosine_similarity_unit_core
    import csu_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [ELEM_WIDTH-1:0] elem_a,
    input  logic signed [ELEM_WIDTH-1:0] elem_b,
    input  logic                         is_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [SIM_W-1:0]      similarity,
    output logic                         zero_norm
);

    // finished sums, front to queue
    logic push;
    vec_t push_data;
    logic full;

    // queue to back
    logic pop;
    vec_t pop_data;
    logic empty;

    // front: products and saturating sums, one pair per cycle while not stalled
    csu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .is_last   (is_last),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // decouples the per-pair front from the per-vector back
    csu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // back: norm product, rounded quotient search, clamp and output register
    csu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .zero_norm  (zero_norm)
    );

endmodule

@@ tb/tb.sv @@
// self-checking testbench of the cosine similarity unit with its own cosine predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csu_pkg::*;

    // one element pair on the way in
    typedef struct {
        elem_t a;
        elem_t b;
        logic  last;
        logic  drain;   // hold this pair back until every cosine has come out
    } pair_t;

    // one cosine on the way out
    typedef struct {
        logic signed [SIM_W-1:0] sim;
        logic                    zero;
    } cosine_t;

    // content of a generated vector pair
    typedef enum int {
        VEC_FULL,       // both elements over the whole range
        VEC_SMALL,      // small magnitudes around zero
        VEC_EDGE,       // only extremes, zero and one lsb
        VEC_ZERO_A,     // first vector all zero
        VEC_ZERO_B,     // second vector all zero
        VEC_SAME,       // b equals a, cosine at the clamp
        VEC_MIRROR      // b is minus a
    } vec_style_t;

    // receiver stall patterns
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_LONG,
        STALL_RARE
    } stall_mode_t;

    localparam longint ACC_MAX  = (longint'(1) << (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_MIN  = -ACC_MAX - 1;
    localparam int     N_RANDOM = 1700;
    localparam int     MAX_SHOWN = 50;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    elem_t                   elem_a    = '0;
    elem_t                   elem_b    = '0;
    logic                    is_last   = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;

    pair_t   pairs_to_send[$];
    cosine_t cosines_due[$];

    // predictor copy of the three running sums
    longint dot_sum;
    longint norm_a_sum;
    longint norm_b_sum;

    int          mismatch_count = 0;
    logic        pair_accepted  = 1'b0;
    pair_t       send_pair;
    int          burst_left     = 0;
    int          gap_left       = 0;
    stall_mode_t stall_mode     = STALL_NONE;
    int          stall_left     = 0;
    int          stall_phase    = 0;

    cosine_similarity_unit_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .zero_norm  (zero_norm)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // add one product into a 42-bit sum, clipping at the signed limits
    function automatic longint sat_sum(longint acc, longint term);
        longint s;
        s = acc + term;
        if (s > ACC_MAX)
            return ACC_MAX;
        if (s < ACC_MIN)
            return ACC_MIN;
        return s;
    endfunction

    // cosine in q2.14: largest q with (q - 1/2) <= 16384*|dot|/sqrt(na*nb),
    // which is round half away from zero; squared on both sides so it stays exact
    function automatic cosine_t cosine_of(longint dot, longint na, longint nb);
        cosine_t      c;
        logic [127:0] target;
        logic [127:0] trial;
        longint       mag;
        int           lo;
        int           hi;
        int           mid;
        c.sim  = '0;
        c.zero = 1'b1;
        if (na == 0 || nb == 0)
            return c;
        c.zero = 1'b0;
        mag    = (dot < 0) ? -dot : dot;
        target = 128'(mag) << 15;
        target = target * target;
        lo     = 0;
        hi     = int'(ONE_Q14);
        // binary search, capped at 1.0 so the clamp falls out for free
        while (lo < hi)
        begin
            mid   = (lo + hi + 1) / 2;
            trial = 128'(2 * mid - 1);
            trial = trial * trial * 128'(na) * 128'(nb);
            if (trial <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        c.sim = SIM_W'((dot < 0) ? -lo : lo);
        return c;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_SHOWN)
            $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    task automatic add_pair(int a, int b, bit last, bit drain = 1'b0);
        pair_t p;
        p.a     = elem_t'(a);
        p.b     = elem_t'(b);
        p.last  = last;
        p.drain = drain;
        pairs_to_send.push_back(p);
    endtask

    function automatic int edge_elem();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    task automatic add_vector(int len, vec_style_t style, bit drain);
        int a;
        int b;
        for (int i = 0; i < len; i++)
        begin
            a = int'(elem_t'($urandom));
            b = int'(elem_t'($urandom));
            case (style)
                VEC_SMALL:
                begin
                    a = int'($urandom_range(0, 16)) - 8;
                    b = int'($urandom_range(0, 16)) - 8;
                end
                VEC_EDGE:
                begin
                    a = edge_elem();
                    b = edge_elem();
                end
                VEC_ZERO_A:    a = 0;
                VEC_ZERO_B:    b = 0;
                VEC_SAME:      b = a;
                VEC_MIRROR:    b = -a;
                default: ;
            endcase
            add_pair(a, b, i == len - 1, drain && i == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: inputs move on the falling edge, in bursts with gaps
    // ------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            elem_a   <= '0;
            elem_b   <= '0;
            is_last  <= 1'b0;
        end
        else if (!in_valid || pair_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pairs_to_send.size() == 0
                     || (pairs_to_send[0].drain && cosines_due.size() != 0))
            begin
                // nothing left, or holding back until the unit has drained
                in_valid <= 1'b0;
            end
            else
            begin
                send_pair = pairs_to_send.pop_front();
                elem_a   <= send_pair.a;
                elem_b   <= send_pair.b;
                is_last  <= send_pair.last;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    // long bursts now and then give stretches with no gaps at all
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                             : $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern, switched between modes at random intervals
    // ------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(50, 400);
            end
            else
                stall_left--;
            case (stall_mode)
                STALL_NONE: out_stall <= 1'b0;
                STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
                // stall runs longer than one vector's back-end time, so the
                // two-entry queue fills and the front has to stall too
                STALL_LONG: out_stall <= (stall_phase % 128) < 100;
                default:    out_stall <= ($urandom_range(0, 7) == 0);
            endcase
            stall_phase++;
        end
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cosine_t want;
        pair_accepted = rst_n && in_valid && !in_stall;
        if (!rst_n)
        begin
            dot_sum    = 0;
            norm_a_sum = 0;
            norm_b_sum = 0;
        end
        else
        begin
            // predictor first, so a result in the same cycle would still match
            if (pair_accepted)
            begin
                dot_sum    = sat_sum(dot_sum, longint'(elem_a) * longint'(elem_b));
                norm_a_sum = sat_sum(norm_a_sum, longint'(elem_a) * longint'(elem_a));
                norm_b_sum = sat_sum(norm_b_sum, longint'(elem_b) * longint'(elem_b));
                if (is_last)
                begin
                    cosines_due.push_back(cosine_of(dot_sum, norm_a_sum, norm_b_sum));
                    dot_sum    = 0;
                    norm_a_sum = 0;
                    norm_b_sum = 0;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (cosines_due.size() == 0)
                    report_mismatch($sformatf("unexpected item: similarity %0d zero_norm %0b",
                                              similarity, zero_norm));
                else
                begin
                    want = cosines_due.pop_front();
                    if (similarity !== want.sim)
                        report_mismatch($sformatf("similarity %0d, expected %0d",
                                                  similarity, want.sim));
                    if (zero_norm !== want.zero)
                        report_mismatch($sformatf("zero_norm %0b, expected %0b",
                                                  zero_norm, want.zero));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int         len;
        int         pick;
        vec_style_t style;

        // directed: extremes, zero norms, sign, clamp, orthogonal, partial cosine
        add_pair(32767, 32767, 1'b1);           // exactly +1.0
        add_pair(-32768, 32767, 1'b1);          // opposite signs, -1.0
        add_pair(-32768, -32768, 1'b1);         // most negative both sides
        add_pair(1, 1, 1'b1);                   // smallest nonzero
        add_pair(1, -1, 1'b1);
        add_pair(0, 0, 1'b1);                   // both norms zero
        add_pair(0, 100, 1'b1);                 // first norm zero
        add_pair(-1, 0, 1'b1);                  // second norm zero
        add_pair(1, 0, 1'b0);                   // orthogonal: zero, but no flag
        add_pair(0, 1, 1'b1);
        add_pair(256, 768, 1'b0);               // (1,0) against (3,4): 0.6
        add_pair(0, 1024, 1'b1);
        add_pair(-32768, 1, 1'b0);              // mixed signs and sizes
        add_pair(32767, -1, 1'b0);
        add_pair(1, 32767, 1'b1);
        add_pair(16'h5555, -16'sh5556, 1'b0);   // alternating bit patterns
        add_pair(-16'sh5556, 16'h5555, 1'b1);
        add_pair(1, 32767, 1'b0);               // tiny cosine
        add_pair(32767, 1, 1'b1);

        // random vectors; the first one waits for the unit to drain
        add_vector(3, VEC_FULL, 1'b1);
        while (pairs_to_send.size() < N_RANDOM)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                len = $urandom_range(1, 6);
            else if (pick <= 7)
                len = $urandom_range(7, 32);
            else if (pick == 8)
                len = 1;
            else
                len = $urandom_range(33, 150);
            pick = $urandom_range(0, 19);
            if (pick <= 9)
                style = VEC_FULL;
            else if (pick <= 11)
                style = VEC_SMALL;
            else if (pick <= 13)
                style = VEC_EDGE;
            else if (pick == 14)
                style = VEC_ZERO_A;
            else if (pick == 15)
                style = VEC_ZERO_B;
            else if (pick <= 17)
                style = VEC_SAME;
            else
                style = VEC_MIRROR;
            add_vector(len, style, $urandom_range(0, 39) == 0);
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // every item handed over, then every cosine back, then a quiet spell
        while (pairs_to_send.size() != 0 || in_valid)
            @(negedge clk);
        while (cosines_due.size() != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard limit on the run, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
